[hw/rtl/pct_pkg.sv]
// Shared widths, codes and constants of the PPS capture time translator.
`default_nettype none

package pct_pkg;

  localparam int DATA_W    = 64;
  localparam int EPOCH_W   = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int SECS_W    = 45;
  localparam int NANOS_W   = 31;
  // Width of a remainder left by a division by one million.
  localparam int US_REM_W  = 20;
  localparam int CNT_W     = $clog2(DATA_W + 1);

  localparam longint unsigned MICROS_PER_SECOND = 64'd1000000;
  localparam longint unsigned NANOS_PER_MICRO   = 64'd1000;
  localparam logic [EPOCH_W-1:0] VALID_EPOCH_RESET = 32'd155520000;

  typedef enum logic [OP_W-1:0] {
    OP_LOG   = 2'd0,
    OP_LATCH = 2'd1,
    OP_XLATE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOGGED     = 3'd0,
    ST_LATCHED    = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_TRANSLATED = 3'd3,
    ST_INVALID    = 3'd4
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/pct_chan_if.sv]
// Handshake interfaces for the command and result channels.
`default_nettype none

interface pct_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [pct_pkg::OP_W-1:0]       operation;
  logic [pct_pkg::DATA_W-1:0]     capture_value;
  logic [pct_pkg::EPOCH_W-1:0]    pps_epoch;

  modport source (output valid, operation, capture_value, pps_epoch, input ready);
  modport sink   (input valid, operation, capture_value, pps_epoch, output ready);
endinterface

interface pct_res_if;
  logic                              valid;
  logic                              ready;
  logic [pct_pkg::STATUS_W-1:0]      status;
  logic signed [pct_pkg::DATA_W-1:0] epoch_microseconds;
  logic signed [pct_pkg::SECS_W-1:0] whole_seconds;
  logic signed [pct_pkg::NANOS_W-1:0] nanoseconds;

  modport source (output valid, status, epoch_microseconds, whole_seconds, nanoseconds,
                  input ready);
  modport sink   (input valid, status, epoch_microseconds, whole_seconds, nanoseconds,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/pct_serial_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module pct_serial_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pct_pkg::DATA_W-1:0] dividend,
  input  wire logic [pct_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [pct_pkg::DATA_W-1:0]      quotient,
  output logic [pct_pkg::DATA_W-1:0]      remainder
);
  import pct_pkg::*;

  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done_q;
  logic [DATA_W+1:0] trial;

  // The dividend shifts out of the top of the quotient register as the
  // quotient bits shift in at the bottom.
  assign trial = {1'b0, rem, quo[DATA_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DATA_W+1]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done      = done_q;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

[hw/rtl/pps_capture_time_translator_top.sv]
// Top level of the PPS capture time translator: ring, reference and sequencer.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  cmd      | in        | operation, capture_value, pps_epoch
//  res      | out       | status, epoch_microseconds, whole_seconds, nanoseconds
//  cfg      | in        | cfg_wen, cfg_wdata (min_valid_epoch)
//
// A log item goes from acceptance through S_DONE to the result register, and
// a latch item through S_LRD, S_LCMP and S_DONE. A valid translate makes two
// passes of the bit-serial divider, one bit per cycle each, and runs the
// shift-add multiplier over the bits of the span. The block takes one item at
// a time; a finished result waits in the output register while the next item
// is accepted. Reset is synchronous and clears the ring valid bits, the ring
// index and the reference.
`default_nettype none

module pps_capture_time_translator_top #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pct_cmd_if.sink                          cmd,
  pct_res_if.source                        res,
  input  wire logic                        cfg_wen,
  input  wire logic [pct_pkg::EPOCH_W-1:0] cfg_wdata
);
  import pct_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [DATA_W-1:0] SPAN_US = DATA_W'(RING_DEPTH - 1) * MICROS_PER_SECOND;
  localparam int MUL_W = $clog2(SPAN_US + 64'd1);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LRD  = 14'b00000000000010,
    S_LCMP = 14'b00000000000100,
    S_OFS  = 14'b00000000001000,
    S_MUL  = 14'b00000000010000,
    S_NEG  = 14'b00000000100000,
    S_DS1  = 14'b00000001000000,
    S_DW1  = 14'b00000010000000,
    S_ADD  = 14'b00000100000000,
    S_DS2  = 14'b00001000000000,
    S_DW2  = 14'b00010000000000,
    S_FIN  = 14'b00100000000000,
    S_DONE = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [EPOCH_W-1:0] min_valid_epoch;

  // Ring storage.
  logic [EPOCH_W-1:0]    ring_epochs   [RING_DEPTH];
  logic [DATA_W-1:0]     ring_captures [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  logic [IDX_W-1:0]      newest_index;
  logic [IDX_W-1:0]      idx_inc;
  logic [EPOCH_W-1:0]    rd_new_ep;
  logic [EPOCH_W-1:0]    rd_old_ep;
  logic [DATA_W-1:0]     rd_new_cap;
  logic [DATA_W-1:0]     rd_old_cap;
  logic                  rd_new_vld;
  logic                  rd_old_vld;
  logic [EPOCH_W-1:0]    new_ep;
  logic [EPOCH_W-1:0]    old_ep;
  logic [DATA_W-1:0]     new_cap;
  logic [DATA_W-1:0]     old_cap;
  logic [EPOCH_W:0]      ep_diff;

  // Reference pair. The second span is always minus (RING_DEPTH-1) for a
  // reference that can pass the validity check, so it is folded into SPAN_US.
  logic [EPOCH_W-1:0] ref_new_epoch;
  logic [EPOCH_W-1:0] ref_old_epoch;
  logic [DATA_W-1:0]  ref_new_capture;
  logic [DATA_W-1:0]  ref_tick_span;

  // Datapath.
  logic [DATA_W-1:0] cap_q;
  logic [DATA_W-1:0] mc1;
  logic [DATA_W-1:0] mc2;
  logic [DATA_W-1:0] acc1;
  logic [DATA_W-1:0] acc2;
  logic [MUL_W-1:0]  k1;
  logic [MUL_W-1:0]  k2;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] qs;
  logic              qneg;
  logic              us_neg;

  logic                div_start;
  logic [DATA_W-1:0]   div_dividend;
  logic [DATA_W-1:0]   div_divisor;
  logic                div_done;
  logic [DATA_W-1:0]   div_quo;
  logic [DATA_W-1:0]   div_rem;
  logic [DATA_W-1:0]   quo_signed;
  logic [NANOS_W-1:0]  ns_mag;

  // Pending result and output register.
  logic [STATUS_W-1:0] pend_status;
  logic [DATA_W-1:0]   pend_us;
  logic [SECS_W-1:0]   pend_secs;
  logic [NANOS_W-1:0]  pend_ns;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_us;
  logic [SECS_W-1:0]   out_secs;
  logic [NANOS_W-1:0]  out_ns;

  logic cmd_fire;
  logic ref_ok;
  logic out_free;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;
  assign idx_inc   = (newest_index == IDX_W'(RING_DEPTH - 1)) ? '0 : newest_index + 1'b1;

  assign ref_ok = (ref_new_epoch > min_valid_epoch) && (ref_old_epoch > min_valid_epoch) &&
                  (ref_tick_span != '0);

  // Entries never written since reset read as zero.
  assign new_ep  = rd_new_vld ? rd_new_ep  : '0;
  assign old_ep  = rd_old_vld ? rd_old_ep  : '0;
  assign new_cap = rd_new_vld ? rd_new_cap : '0;
  assign old_cap = rd_old_vld ? rd_old_cap : '0;
  assign ep_diff = {1'b0, new_ep} - {1'b0, old_ep};

  assign quo_signed = (state == S_DW1 ? qneg : us_neg) ? DATA_W'(0) - div_quo : div_quo;
  assign ns_mag     = NANOS_W'(div_rem[US_REM_W-1:0]) * NANOS_W'(NANOS_PER_MICRO);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod[DATA_W-1] ? DATA_W'(0) - prod : prod;
    div_divisor  = ref_tick_span[DATA_W-1] ? DATA_W'(0) - ref_tick_span : ref_tick_span;
    case (state)
      S_DS1: begin
        div_start = 1'b1;
      end
      S_DS2: begin
        div_start    = 1'b1;
        div_dividend = pend_us[DATA_W-1] ? DATA_W'(0) - pend_us : pend_us;
        div_divisor  = MICROS_PER_SECOND;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pct_serial_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd.operation)
            OP_LOG:   state_next = S_DONE;
            OP_LATCH: state_next = S_LRD;
            OP_XLATE: state_next = ref_ok ? S_OFS : S_DONE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LRD:   state_next = S_LCMP;
      S_LCMP:  state_next = S_DONE;
      S_OFS:   state_next = S_MUL;
      S_MUL:   state_next = ((k1 >> 1) == '0 && (k2 >> 1) == '0) ? S_NEG : S_MUL;
      S_NEG:   state_next = S_DS1;
      S_DS1:   state_next = S_DW1;
      S_DW1:   state_next = div_done ? S_ADD : S_DW1;
      S_ADD:   state_next = S_DS2;
      S_DS2:   state_next = S_DW2;
      S_DW2:   state_next = div_done ? S_FIN : S_DW2;
      S_FIN:   state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      min_valid_epoch <= VALID_EPOCH_RESET;
      ring_vld        <= '0;
      newest_index    <= '0;
      ref_new_epoch   <= '0;
      ref_old_epoch   <= '0;
      ref_new_capture <= '0;
      ref_tick_span   <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        min_valid_epoch <= cfg_wdata;
      end
      if (cmd_fire && cmd.operation == OP_LOG) begin
        newest_index      <= idx_inc;
        ring_vld[idx_inc] <= 1'b1;
      end
      if (state == S_LCMP) begin
        if (ep_diff == (EPOCH_W + 1)'(RING_DEPTH - 1)) begin
          ref_new_epoch   <= new_ep;
          ref_old_epoch   <= old_ep;
          ref_new_capture <= new_cap;
          ref_tick_span   <= old_cap - new_cap;
        end else begin
          ref_new_epoch   <= '0;
          ref_old_epoch   <= '0;
          ref_new_capture <= '0;
          ref_tick_span   <= '0;
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.operation == OP_LOG) begin
      ring_epochs[idx_inc]   <= cmd.pps_epoch;
      ring_captures[idx_inc] <= cmd.capture_value;
    end
    if (state == S_LRD) begin
      rd_new_ep  <= ring_epochs[newest_index];
      rd_new_cap <= ring_captures[newest_index];
      rd_old_ep  <= ring_epochs[idx_inc];
      rd_old_cap <= ring_captures[idx_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LRD) begin
      rd_new_vld <= ring_vld[newest_index];
      rd_old_vld <= ring_vld[idx_inc];
    end
  end

  // Datapath and pending result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cap_q     <= cmd.capture_value;
        pend_us   <= '0;
        pend_secs <= '0;
        pend_ns   <= '0;
        pend_status <= (cmd.operation == OP_LOG) ? ST_LOGGED : ST_INVALID;
      end
      S_LCMP: begin
        pend_status <= (ep_diff == (EPOCH_W + 1)'(RING_DEPTH - 1)) ? ST_LATCHED : ST_REJECTED;
      end
      S_OFS: begin
        mc1  <= cap_q - ref_new_capture;
        mc2  <= DATA_W'(ref_new_epoch);
        acc1 <= '0;
        acc2 <= '0;
        k1   <= SPAN_US[MUL_W-1:0];
        k2   <= MUL_W'(MICROS_PER_SECOND);
      end
      S_MUL: begin
        // offset times the span in microseconds, and the newest epoch in
        // microseconds, one bit of each constant per cycle.
        if (k1[0]) begin
          acc1 <= acc1 + mc1;
        end
        if (k2[0]) begin
          acc2 <= acc2 + mc2;
        end
        mc1 <= {mc1[DATA_W-2:0], 1'b0};
        mc2 <= {mc2[DATA_W-2:0], 1'b0};
        k1  <= k1 >> 1;
        k2  <= k2 >> 1;
      end
      S_NEG: begin
        prod <= DATA_W'(0) - acc1;
      end
      S_DS1: begin
        qneg <= prod[DATA_W-1] ^ ref_tick_span[DATA_W-1];
      end
      S_DW1: begin
        if (div_done) begin
          qs <= quo_signed;
        end
      end
      S_ADD: begin
        pend_us <= qs + acc2;
      end
      S_DS2: begin
        us_neg <= pend_us[DATA_W-1];
      end
      S_FIN: begin
        pend_status <= ST_TRANSLATED;
        pend_secs   <= quo_signed[SECS_W-1:0];
        pend_ns     <= us_neg ? NANOS_W'(0) - ns_mag : ns_mag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status <= pend_status;
      out_us     <= pend_us;
      out_secs   <= pend_secs;
      out_ns     <= pend_ns;
    end
  end

  assign res.valid              = out_valid;
  assign res.status             = out_status;
  assign res.epoch_microseconds = out_us;
  assign res.whole_seconds      = out_secs;
  assign res.nanoseconds        = out_ns;

endmodule

`default_nettype wire

[hw/rtl/pct_checker.sv]
// Port-level assertions for the translator, bound to its top level.
`default_nettype none

module pct_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cmd_valid,
  input wire logic                                cmd_ready,
  input wire logic [pct_pkg::OP_W-1:0]            cmd_operation,
  input wire logic                                res_valid,
  input wire logic                                res_ready,
  input wire logic [pct_pkg::STATUS_W-1:0]        res_status,
  input wire logic [pct_pkg::DATA_W-1:0]          res_us,
  input wire logic [pct_pkg::SECS_W-1:0]          res_secs,
  input wire logic [pct_pkg::NANOS_W-1:0]         res_ns
);
  import pct_pkg::*;

  // A result that is not taken holds still.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_us))
    else $error("result changed while stalled");

  // Any item with a result keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready &&
    (cmd_operation == OP_LOG || cmd_operation == OP_LATCH || cmd_operation == OP_XLATE)
    |=> !cmd_ready)
    else $error("command accepted without the block going busy");

  // Only a translation carries time fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_TRANSLATED |->
    res_us == '0 && res_secs == '0 && res_ns == '0)
    else $error("time fields set on a result that is not a translation");

  // Seconds and nanoseconds follow the sign of the microsecond value.
  a_sign_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_TRANSLATED |->
    (res_ns == '0 || res_ns[NANOS_W-1] == res_us[DATA_W-1]) &&
    (res_secs == '0 || res_secs[SECS_W-1] == res_us[DATA_W-1]))
    else $error("split time fields disagree in sign");

endmodule

bind pps_capture_time_translator_top pct_checker u_pct_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_operation (cmd.operation),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_status    (res.status),
  .res_us        (res.epoch_microseconds),
  .res_secs      (res.whole_seconds),
  .res_ns        (res.nanoseconds)
);

`default_nettype wire

[tb/sv/pps_capture_time_translator_top_tb.sv]
// Self-checking testbench for the PPS capture time translator.
module pps_capture_time_translator_top_tb;
  import pct_pkg::*;

  localparam int RING_SLOTS = 8;
  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int LAST_PHASE = 5;
  localparam longint unsigned DIRECTED_TICKS = 64'd10000000;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  capture;
    logic [EPOCH_W-1:0] epoch;
  } pps_cmd_t;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  micros;
    logic signed [SECS_W-1:0]  secs;
    logic signed [NANOS_W-1:0] nanos;
  } stamp_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [EPOCH_W-1:0] cfg_wdata;

  pct_cmd_if cmd_ch ();
  pct_res_if res_ch ();

  pps_capture_time_translator_top #(.RING_DEPTH(RING_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Commands waiting to be offered, and stamps waiting to come out.
  pps_cmd_t cmd_backlog[$];
  stamp_t   pending_stamps[$];
  pps_cmd_t on_offer;
  int issued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int phase_no = 0;
  logic long_hold;

  // Predictor state: PPS ring, anchor pair and the validity floor.
  logic [EPOCH_W-1:0] pps_epochs [RING_SLOTS] = '{default: '0};
  logic [DATA_W-1:0]  pps_captures [RING_SLOTS] = '{default: '0};
  logic [SLOT_W-1:0]  head_slot = '0;
  logic [EPOCH_W-1:0] anchor_new_epoch = '0;
  logic [EPOCH_W-1:0] anchor_old_epoch = '0;
  logic [DATA_W-1:0]  anchor_capture = '0;
  logic [DATA_W-1:0]  anchor_ticks = '0;
  logic [32:0]        anchor_seconds = '0;
  logic [EPOCH_W-1:0] epoch_floor = VALID_EPOCH_RESET;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] magnitude_of(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  // Two's complement division truncating toward zero.
  function automatic logic [DATA_W-1:0] trunc_div(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] q;
    q = magnitude_of(a) / magnitude_of(b);
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic void clear_anchor();
    anchor_new_epoch = '0;
    anchor_old_epoch = '0;
    anchor_capture = '0;
    anchor_ticks = '0;
    anchor_seconds = '0;
  endfunction

  function automatic void predict_stamp(pps_cmd_t c);
    stamp_t s;
    logic [SLOT_W-1:0] oldest;
    logic [32:0] epoch_gap;
    logic [DATA_W-1:0] span, offset, prod, us, rem;
    s.status = ST_LOGGED;
    s.micros = '0;
    s.secs = '0;
    s.nanos = '0;
    case (c.op)
      OP_LOG: begin
        head_slot = (head_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : head_slot + 1'b1;
        pps_epochs[head_slot] = c.epoch;
        pps_captures[head_slot] = c.capture;
      end
      OP_LATCH: begin
        oldest = (head_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : head_slot + 1'b1;
        epoch_gap = {1'b0, pps_epochs[head_slot]} - {1'b0, pps_epochs[oldest]};
        if (epoch_gap != 33'(RING_SLOTS - 1)) begin
          clear_anchor();
          s.status = ST_REJECTED;
        end else begin
          anchor_new_epoch = pps_epochs[head_slot];
          anchor_old_epoch = pps_epochs[oldest];
          anchor_capture = pps_captures[head_slot];
          anchor_ticks = pps_captures[oldest] - pps_captures[head_slot];
          anchor_seconds = {1'b0, anchor_old_epoch} - {1'b0, anchor_new_epoch};
          s.status = ST_LATCHED;
        end
      end
      OP_XLATE: begin
        if (!(anchor_new_epoch > epoch_floor && anchor_old_epoch > epoch_floor) ||
            anchor_ticks == '0) begin
          s.status = ST_INVALID;
        end else begin
          span = {{(DATA_W-33){anchor_seconds[32]}}, anchor_seconds};
          offset = c.capture - anchor_capture;
          prod = offset * span * MICROS_PER_SECOND;
          us = trunc_div(prod, anchor_ticks) + {32'b0, anchor_new_epoch} * MICROS_PER_SECOND;
          rem = magnitude_of(us) % MICROS_PER_SECOND;
          if (us[DATA_W-1]) rem = -rem;
          s.status = ST_TRANSLATED;
          s.micros = us;
          s.secs = SECS_W'(trunc_div(us, MICROS_PER_SECOND));
          s.nanos = NANOS_W'(rem * NANOS_PER_MICRO);
        end
      end
      default: return;
    endcase
    pending_stamps.push_back(s);
  endfunction

  // Sender: offers the backlog, idling at random, and predicts each accepted item.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        accepted_total++;
        predict_stamp(on_offer);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_offer = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.operation <= on_offer.op;
          cmd_ch.capture_value <= on_offer.capture;
          cmd_ch.pps_epoch <= on_offer.epoch;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
  end

  // Receiver: each accepted item is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_stamps.size() == 0) begin
        $error("unexpected result item with status %0d", res_ch.status);
        mismatches++;
      end else begin
        stamp_t want;
        want = pending_stamps.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatches++;
        end
        if (res_ch.epoch_microseconds !== want.micros) begin
          $error("epoch_microseconds: expected %0d, got %0d", want.micros,
                 res_ch.epoch_microseconds);
          mismatches++;
        end
        if (res_ch.whole_seconds !== want.secs) begin
          $error("whole_seconds: expected %0d, got %0d", want.secs, res_ch.whole_seconds);
          mismatches++;
        end
        if (res_ch.nanoseconds !== want.nanos) begin
          $error("nanoseconds: expected %0d, got %0d", want.nanos, res_ch.nanoseconds);
          mismatches++;
        end
      end
    end
  end

  // One long receiver hold-off early in the first random phase, so the block backs up.
  initial begin
    long_hold = 1'b0;
    wait (phase_no == 1);
    repeat (20) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] capture,
                           input logic [EPOCH_W-1:0] epoch);
    pps_cmd_t c;
    c.op = op;
    c.capture = capture;
    c.epoch = epoch;
    cmd_backlog.push_back(c);
    issued_total++;
  endtask

  task automatic wait_for_drain();
    while (accepted_total != issued_total || pending_stamps.size() != 0) @(posedge clk);
  endtask

  task automatic write_epoch_floor(input logic [EPOCH_W-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    epoch_floor = value;
  endtask

  // A run of PPS events with steady epochs and tick rate, a latch and a few
  // translations after it; sometimes short, glitched or at awkward epochs.
  task automatic queue_pps_burst(output int n);
    logic [EPOCH_W-1:0] base, ep;
    logic [DATA_W-1:0] rate, cap0, cap;
    int pick, logs, glitch, xlates;
    n = 0;
    pick = $urandom_range(99);
    if (pick < 70 && epoch_floor < 32'hFFF0_0000)
      base = epoch_floor + 1 + $urandom_range(0, 1000000);
    else if (pick < 80)
      base = epoch_floor - $urandom_range(0, 7);
    else if (pick < 90)
      base = 32'hFFFF_FFF8 - $urandom_range(0, 3) + $urandom_range(0, 6);
    else
      base = $urandom;
    pick = $urandom_range(99);
    if (pick < 60) rate = DATA_W'($urandom_range(1000, 100000000));
    else if (pick < 80) rate = {$urandom, $urandom};
    else rate = DATA_W'($urandom_range(0, 3));
    cap0 = {$urandom, $urandom};
    glitch = ($urandom_range(99) < 15) ? $urandom_range(0, 7) : -1;
    logs = ($urandom_range(99) < 10) ? $urandom_range(1, 7) : 8;
    for (int i = 0; i < logs; i++) begin
      ep = base + i + ((i == glitch) ? 1 : 0);
      cap = cap0 + rate * i + $urandom_range(0, 3);
      queue_cmd(OP_LOG, cap, ep);
      n++;
    end
    queue_cmd(OP_LATCH, {$urandom, $urandom}, $urandom);
    n++;
    xlates = $urandom_range(1, 4);
    for (int i = 0; i < xlates; i++) begin
      if ($urandom_range(99) < 20) cap = {$urandom, $urandom};
      else cap = cap0 + rate * $urandom_range(0, 10) + $urandom_range(0, 100000);
      queue_cmd(OP_XLATE, cap, $urandom);
      n++;
    end
  endtask

  initial begin
    logic [EPOCH_W-1:0] e0;
    logic [OP_W-1:0] op;
    int count, n;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = '0;
    cmd_ch.capture_value = '0;
    cmd_ch.pps_epoch = '0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset floor.
    e0 = VALID_EPOCH_RESET;
    queue_cmd(OP_XLATE, 64'd5, '0);
    queue_cmd(OP_LATCH, '0, '0);
    queue_cmd(OP_UNUSED, '1, '1);
    for (int i = 0; i < 8; i++) queue_cmd(OP_LOG, DIRECTED_TICKS * i, e0 + i);
    // The oldest epoch equals the floor, so the pair latches but is not valid.
    queue_cmd(OP_LATCH, '0, '0);
    queue_cmd(OP_XLATE, DIRECTED_TICKS * 3, '0);
    queue_cmd(OP_LOG, DIRECTED_TICKS * 8, e0 + 8);
    queue_cmd(OP_LATCH, '0, '0);
    queue_cmd(OP_XLATE, '1, '0);
    queue_cmd(OP_XLATE, '0, '0);
    queue_cmd(OP_XLATE, DIRECTED_TICKS * 5 + 12345, '1);
    // The newest capture repeats the oldest, giving a zero tick span.
    queue_cmd(OP_LOG, DIRECTED_TICKS * 2, e0 + 9);
    queue_cmd(OP_LATCH, '0, '0);
    queue_cmd(OP_XLATE, DIRECTED_TICKS * 9, '0);
    // Newest epoch below the oldest one: the exact difference is negative.
    queue_cmd(OP_LOG, '1, '1);
    queue_cmd(OP_LOG, '0, '0);
    queue_cmd(OP_LATCH, '1, '1);
    wait_for_drain();

    for (int p = 1; p <= LAST_PHASE; p++) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        1: begin write_epoch_floor('0); send_idle_pct = 0; stall_pct = 0; end
        2: begin write_epoch_floor('1); send_idle_pct = 51; stall_pct = 0; end
        3: begin write_epoch_floor($urandom_range(0, 200000000)); send_idle_pct = 0;
                 stall_pct = 51; end
        4: begin write_epoch_floor(VALID_EPOCH_RESET); send_idle_pct = 10; stall_pct = 10; end
        default: begin write_epoch_floor($urandom); send_idle_pct = 0; stall_pct = 0; end
      endcase
      phase_no = p;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 80) begin
          queue_pps_burst(n);
          count += n;
        end else begin
          op = OP_W'($urandom_range(0, 3));
          queue_cmd(op, {$urandom, $urandom}, $urandom);
          if (op != OP_UNUSED) count++;
        end
      end
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_stamps.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
